// ----- design/lacq_pkg.sv -----
// ============================================================================
// lacq_pkg: shared types and constants for the linear array queue
// Holds the queue depth, operation and status codes, and the command and
// status bundles between the controller and the datapath.
// ============================================================================
package lacq_pkg;

  localparam int DEPTH = 8;
  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DATA_W = 32;

  typedef enum logic [1:0] {
    OP_ENQ  = 2'd0,
    OP_DEQ  = 2'd1,
    OP_PEEK = 2'd2,
    OP_DISP = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // What the output register takes on a load.
  typedef enum logic [2:0] {
    RES_ACK,    // ok, zero value, last
    RES_FULL,   // full, zero value, last
    RES_EMPTY,  // empty, zero value, last
    RES_FRONT,  // ok, entry at read address, last
    RES_ENTRY   // ok, entry at read address, last when it is the rear
  } res_e;

  typedef enum logic {
    S_IDLE,
    S_DISP
  } state_e;

  typedef struct packed {
    logic out_load;
    res_e res;
    logic use_front;  // read address is the front index, else the cursor
    logic enq;
    logic deq;
  } cmd_t;

  typedef struct packed {
    logic out_free;       // output register can take a word this cycle
    logic holds;
    logic full;
    logic front_at_rear;  // front index equals the rear index
    logic cur_at_rear;    // display cursor equals the rear index
  } stat_t;

endpackage

// ----- design/lacq_ctrl.sv -----
// ============================================================================
// lacq_ctrl: queue controller
// Decodes each operation and steps through a display one entry per cycle while the output register is free.
// ============================================================================
module lacq_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic [1:0]      operation_i,
  input  lacq_pkg::stat_t stat_i,
  output lacq_pkg::cmd_t  cmd_o
);
  import lacq_pkg::*;

  state_e state_q, state_d;
  op_e    op;

  assign op = op_e'(operation_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d         = state_q;
    in_ready_o      = 1'b0;
    cmd_o.out_load  = 1'b0;
    cmd_o.res       = RES_ACK;
    cmd_o.use_front = 1'b1;
    cmd_o.enq       = 1'b0;
    cmd_o.deq       = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = stat_i.out_free;
        if (in_valid_i && stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          case (op)
            OP_ENQ: begin
              if (stat_i.holds && stat_i.full) begin
                cmd_o.res = RES_FULL;
              end else begin
                cmd_o.res = RES_ACK;
                cmd_o.enq = 1'b1;
              end
            end
            OP_DEQ: begin
              if (stat_i.holds) begin
                cmd_o.res = RES_FRONT;
                cmd_o.deq = 1'b1;
              end else begin
                cmd_o.res = RES_EMPTY;
              end
            end
            OP_PEEK: begin
              cmd_o.res = stat_i.holds ? RES_FRONT : RES_EMPTY;
            end
            default: begin
              if (stat_i.holds) begin
                cmd_o.res = RES_ENTRY;
                if (!stat_i.front_at_rear) begin
                  state_d = S_DISP;
                end
              end else begin
                cmd_o.res = RES_EMPTY;
              end
            end
          endcase
        end
      end
      S_DISP: begin
        cmd_o.use_front = 1'b0;
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.res      = RES_ENTRY;
          if (stat_i.cur_at_rear) begin
            state_d = S_IDLE;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

endmodule

// ----- design/lacq_dp.sv -----
// ============================================================================
// lacq_dp: queue datapath
// Entry store, front and rear indices, display cursor and output register.
// ============================================================================
module lacq_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lacq_pkg::cmd_t                cmd_i,
  output lacq_pkg::stat_t               stat_o,
  input  logic signed [lacq_pkg::DATA_W-1:0] item_value_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [1:0]                    status_o,
  output logic signed [lacq_pkg::DATA_W-1:0] value_o,
  output logic                          last_o
);
  import lacq_pkg::*;

  localparam logic [IDX_W-1:0] LastIdx = IDX_W'(DEPTH - 1);

  logic [DATA_W-1:0] store_q [DEPTH];

  logic [IDX_W-1:0] front_q, front_d;
  logic [IDX_W-1:0] rear_q, rear_d;
  logic [IDX_W-1:0] cur_q, cur_d;
  logic             holds_q, holds_d;
  logic             out_valid_q, out_valid_d;
  logic [1:0]       status_q, status_d;
  logic [DATA_W-1:0] value_q, value_d;
  logic             last_q, last_d;

  logic [IDX_W-1:0] raddr;
  logic [IDX_W-1:0] waddr;
  logic [DATA_W-1:0] rdata;

  assign raddr = cmd_i.use_front ? front_q : cur_q;
  assign rdata = store_q[raddr];
  assign waddr = holds_q ? rear_q + 1'b1 : '0;

  assign stat_o.out_free      = !out_valid_q || out_ready_i;
  assign stat_o.holds         = holds_q;
  assign stat_o.full          = (rear_q == LastIdx);
  assign stat_o.front_at_rear = (front_q == rear_q);
  assign stat_o.cur_at_rear   = (cur_q == rear_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.enq) begin
      store_q[waddr] <= item_value_i;
    end
  end

  always_comb begin
    front_d     = front_q;
    rear_d      = rear_q;
    holds_d     = holds_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q;
    status_d    = status_q;
    value_d     = value_q;
    last_d      = last_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (cmd_i.enq) begin
      rear_d  = waddr;
      holds_d = 1'b1;
      if (!holds_q) begin
        front_d = '0;
      end
    end

    if (cmd_i.deq) begin
      if (front_q == rear_q) begin
        front_d = '0;
        rear_d  = '0;
        holds_d = 1'b0;
      end else begin
        front_d = front_q + 1'b1;
      end
    end

    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
      status_d    = ST_OK;
      value_d     = '0;
      last_d      = 1'b1;
      case (cmd_i.res)
        RES_ACK:   status_d = ST_OK;
        RES_FULL:  status_d = ST_FULL;
        RES_EMPTY: status_d = ST_EMPTY;
        RES_FRONT: value_d  = rdata;
        RES_ENTRY: begin
          value_d = rdata;
          last_d  = (raddr == rear_q);
          cur_d   = raddr + 1'b1;
        end
        default:   status_d = ST_OK;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q     <= '0;
      rear_q      <= '0;
      holds_q     <= 1'b0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      front_q     <= front_d;
      rear_q      <= rear_d;
      holds_q     <= holds_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    value_q  <= value_d;
    last_q   <= last_d;
  end

  assign out_valid_o = out_valid_q;
  assign status_o    = status_q;
  assign value_o     = value_q;
  assign last_o      = last_q;

endmodule

// ----- design/linear_array_queue.sv -----
// ============================================================================
// linear_array_queue: non-circular array queue with display walk
// Enqueue, dequeue, peek and display on a store of DEPTH signed words.
// ============================================================================
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------------
//  in      | input     | in_valid_i / in_ready_o | operation_i, item_value_i
//  out     | output    | out_valid_o / out_ready_i | status_o, value_o, last_o
//
//  Enqueue, dequeue and peek each give one word, registered in
//  the output stage the cycle after acceptance.
//  Display gives one word per cycle while the output is not stalled, rear - front + 1 words in all; the
//  controller walks a cursor over the store and takes no new item meanwhile.
//  An item is taken while the output register is empty or being drained.
//  A stall on the output holds the register and the display walk in place.
//  Reset clears the indices, the held flag and the output valid; the entry
//  store has no reset and is only read at slots already written.
//
module linear_array_queue (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         operation_i,
  input  logic signed [lacq_pkg::DATA_W-1:0] item_value_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [1:0]                         status_o,
  output logic signed [lacq_pkg::DATA_W-1:0] value_o,
  output logic                               last_o
);
  import lacq_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Controller: decode each operation, sequence the display walk.
  lacq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .operation_i (operation_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Datapath: store, indices, cursor and the output word register.
  lacq_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .item_value_i (item_value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .value_o      (value_o),
    .last_o       (last_o)
  );

endmodule

// ----- design/lacq_checker.sv -----
// ============================================================================
// lacq_checker: port-level checks for the linear array queue
// Watches both channels and flags broken ordering or malformed words.
// ============================================================================
module lacq_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               in_valid_i,
  input logic                               in_ready_o,
  input logic [1:0]                         operation_i,
  input logic signed [lacq_pkg::DATA_W-1:0] item_value_i,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input logic [1:0]                         status_o,
  input logic signed [lacq_pkg::DATA_W-1:0] value_o,
  input logic                               last_o
);
  import lacq_pkg::*;

  // Hold an offered output word until it is taken.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(value_o) && $stable(status_o)
      && $stable(last_o))
    else $error("output word dropped or changed while stalled");

  // An accepted item always yields a word in the next cycle.
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted item gave no word");

  // Refuse new items while the output word is stalled.
  a_no_take_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("item taken while output stalled");

  // Full and empty words are single, zero-valued words.
  a_err_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL || status_o == ST_EMPTY) |-> last_o && value_o == '0)
    else $error("malformed full or empty word");

endmodule

bind linear_array_queue lacq_checker u_lacq_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .operation_i  (operation_i),
  .item_value_i (item_value_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .status_o     (status_o),
  .value_o      (value_o),
  .last_o       (last_o)
);
